FILE: rtl/core/dht_pkg.sv
// ----------------------------------------------------------------------------
// dht_pkg
// Shared types and constants of the double-hashing table engine.
// ----------------------------------------------------------------------------
package dht_pkg;

  localparam int TableCapacity = 1021;
  localparam int HashPrime     = 1019;
  localparam int IdxW          = $clog2(TableCapacity);
  localparam int CntW          = 11;

  localparam logic [63:0] FnvBasis = 64'hCBF29CE484222325;
  localparam logic [63:0] FnvMult  = 64'h00000100000001B3;

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_DELETE = 2'd1,
    FN_LOOKUP = 2'd2,
    FN_SPARE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_DELETED  = 3'd2,
    ST_FOUND    = 3'd3,
    ST_MISS     = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_REDUCE,
    S_READ,
    S_CHECK,
    S_WRITE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic hash_step;
    logic reduce_step;
    logic probe_rd;
    logic probe_adv;
    logic commit;
    logic finish;
  } dht_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic hash_done;
    logic reduce_done;
    logic zero_key;
    logic hit;
    logic cycle_end;
  } dht_sts_t;

endpackage

FILE: rtl/core/dht_ctrl.sv
// ----------------------------------------------------------------------------
// dht_ctrl
// Sequencer: clear, hash, reduce, probe walk, commit, result.
// ----------------------------------------------------------------------------
module dht_ctrl import dht_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     out_free,
  input  dht_sts_t sts,
  output dht_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (sts.clear_done) state_nxt = S_IDLE;
      S_IDLE:   if (in_valid) state_nxt = S_HASH;
      S_HASH:   if (sts.hash_done) state_nxt = S_REDUCE;
      S_REDUCE: begin
        if (sts.reduce_done) state_nxt = sts.zero_key ? S_WRITE : S_READ;
      end
      S_READ:   state_nxt = S_CHECK;
      S_CHECK:  begin
        if (sts.hit || sts.cycle_end) state_nxt = S_WRITE;
        else                          state_nxt = S_READ;
      end
      S_WRITE:  state_nxt = S_DONE;
      S_DONE:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_CLEAR:  cmd.clear = 1'b1;
      S_IDLE:   begin in_stall = 1'b0; cmd.load = in_valid; end
      S_HASH:   cmd.hash_step = 1'b1;
      S_REDUCE: cmd.reduce_step = 1'b1;
      S_READ:   cmd.probe_rd = 1'b1;
      S_CHECK:  cmd.probe_adv = !(sts.hit || sts.cycle_end);
      S_WRITE:  cmd.commit = 1'b1;
      S_DONE:   cmd.finish = out_free;
      default:  ;
    endcase
  end

endmodule

FILE: rtl/core/dht_datapath.sv
// ----------------------------------------------------------------------------
// dht_datapath
// FNV-1 hash, folding modulo reduction, probe index, table memories, count.
// ----------------------------------------------------------------------------
module dht_datapath import dht_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  dht_cmd_t    cmd,
  output dht_sts_t    sts,
  input  logic [1:0]  in_func,
  input  logic [63:0] in_key,
  input  logic [31:0] in_block_size,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [31:0] out_size_out,
  output logic [9:0]  out_entry_count
);

  localparam int HashSteps = 8;
  localparam int RedSteps  = 10;
  localparam int RedW      = 4;
  localparam int FnvShift  = 40;

  // FnvMult is 2^FnvShift + FnvLow
  localparam logic [63:0] FnvLow    = FnvMult - (64'd1 << FnvShift);
  // 2^IdxW taken modulo the capacity and the prime; ten folds bring a
  // 64-bit value below 2^IdxW
  localparam logic [63:0] FoldCap   = 64'((1 << IdxW) - TableCapacity);
  localparam logic [63:0] FoldPrime = 64'((1 << IdxW) - HashPrime);

  logic [63:0]   key_store [TableCapacity];
  logic [31:0]   size_store [TableCapacity];

  logic [1:0]    func_r;
  logic [63:0]   key_r;
  logic [31:0]   bsize_r;
  logic [63:0]   hash_r;
  logic [3:0]    hcnt_r;
  logic [63:0]   hrem_r, krem_r;
  logic [RedW-1:0] rcnt_r;
  logic [IdxW-1:0] start_r, idx_r, step_r;
  logic [IdxW-1:0] clr_idx_r;
  logic [63:0]   rd_key_r;
  logic [31:0]   rd_size_r;
  logic          hit_r;
  logic [CntW-1:0] count_r;
  logic          out_valid_r;
  logic [2:0]    status_r;
  logic [31:0]   size_o_r;

  logic [63:0]   hmul, hnext;
  logic [63:0]   hfold, kfold;
  logic [IdxW-1:0] hmod, kmod;
  logic [IdxW:0] nidx;
  logic [63:0]   cur_key;
  logic          is_ins, match, empty, cyc_end, commit_ok;
  logic          key_we;
  logic [IdxW-1:0] key_wa;
  logic [63:0]   key_wd;

  assign hmul  = {hash_r[63-FnvShift:0], FnvShift'(0)} + hash_r * FnvLow;
  assign hnext = hmul ^ {56'd0, key_r[8*hcnt_r[2:0] +: 8]};
  assign hfold = ({IdxW'(0), hrem_r[63:IdxW]} * FoldCap) +
                 {(64-IdxW)'(0), hrem_r[IdxW-1:0]};
  assign kfold = ({IdxW'(0), krem_r[63:IdxW]} * FoldPrime) +
                 {(64-IdxW)'(0), krem_r[IdxW-1:0]};
  assign hmod  = (hfold[IdxW-1:0] >= IdxW'(TableCapacity)) ?
                 hfold[IdxW-1:0] - IdxW'(TableCapacity) : hfold[IdxW-1:0];
  assign kmod  = (kfold[IdxW-1:0] >= IdxW'(HashPrime)) ?
                 kfold[IdxW-1:0] - IdxW'(HashPrime) : kfold[IdxW-1:0];
  assign nidx = {1'b0, idx_r} + {1'b0, step_r};
  assign cur_key = rd_key_r;
  assign is_ins  = func_r == FN_INSERT;
  assign match   = cur_key == key_r;
  assign empty   = cur_key == 64'd0;
  assign cyc_end = ((nidx >= (IdxW+1)'(TableCapacity)) ?
                    IdxW'(nidx - (IdxW+1)'(TableCapacity)) : nidx[IdxW-1:0]) == start_r;

  assign sts.clear_done  = clr_idx_r == IdxW'(TableCapacity - 1);
  assign sts.hash_done   = hcnt_r == 4'(HashSteps - 1);
  assign sts.reduce_done = rcnt_r == RedW'(RedSteps - 1);
  assign sts.zero_key    = key_r == 64'd0;
  assign sts.hit         = match || (is_ins && empty);
  assign sts.cycle_end   = cyc_end;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_func;
      key_r   <= in_key;
      bsize_r <= in_block_size;
      hash_r  <= FnvBasis;
      hcnt_r  <= '0;
    end else if (cmd.hash_step) begin
      hash_r <= hnext;
      hrem_r <= hnext;
      krem_r <= key_r;
      hcnt_r <= hcnt_r + 4'd1;
      rcnt_r <= '0;
    end else if (cmd.reduce_step) begin
      hrem_r <= hfold;
      krem_r <= kfold;
      rcnt_r <= rcnt_r + RedW'(1);
      if (sts.reduce_done) begin
        start_r <= hmod;
        idx_r   <= hmod;
        step_r  <= IdxW'(HashPrime) - kmod;
      end
    end else if (cmd.probe_adv) begin
      idx_r <= (nidx >= (IdxW+1)'(TableCapacity)) ?
               IdxW'(nidx - (IdxW+1)'(TableCapacity)) : nidx[IdxW-1:0];
    end
  end

  // clearing pass after reset, one slot per cycle
  always_ff @(posedge clk) begin
    if (!rst_n)         clr_idx_r <= '0;
    else if (cmd.clear) clr_idx_r <= clr_idx_r + IdxW'(1);
  end

  always_ff @(posedge clk) begin
    rd_key_r  <= key_store[idx_r];
    rd_size_r <= size_store[idx_r];
  end

  assign commit_ok = cmd.commit && !sts.zero_key && hit_r;
  assign key_we    = cmd.clear || (commit_ok && (is_ins || func_r == FN_DELETE));
  assign key_wa    = cmd.clear ? clr_idx_r : idx_r;
  assign key_wd    = (cmd.clear || !is_ins) ? 64'd0 : key_r;

  always_ff @(posedge clk) begin
    if (key_we) key_store[key_wa] <= key_wd;
    if (commit_ok && is_ins) size_store[idx_r] <= bsize_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) hit_r <= 1'b0;
    else if (cmd.load) hit_r <= 1'b0;
    else if (cmd.probe_rd) hit_r <= 1'b0;
    else if (sts.hit && !cmd.commit && !cmd.probe_adv && !cmd.finish &&
             !cmd.hash_step && !cmd.reduce_step) hit_r <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish) out_valid_r <= 1'b0;
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
        if (sts.zero_key) begin
          status_r <= ST_FULL;
          size_o_r <= 32'd0;
        end else if (!hit_r) begin
          status_r <= is_ins ? ST_FULL : ST_MISS;
          size_o_r <= 32'd0;
        end else if (is_ins) begin
          size_o_r <= bsize_r;
          if (match) status_r <= ST_UPDATED;
          else begin
            status_r <= ST_INSERTED;
            count_r  <= count_r + CntW'(1);
          end
        end else if (func_r == FN_DELETE) begin
          size_o_r <= rd_size_r;
          status_r <= ST_DELETED;
          count_r  <= count_r - CntW'(1);
        end else begin
          size_o_r <= rd_size_r;
          status_r <= ST_FOUND;
        end
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_size_out    = size_o_r;
  assign out_entry_count = count_r[9:0];

endmodule

FILE: rtl/core/double_hash_table_engine.sv
// ----------------------------------------------------------------------------
// double_hash_table_engine
// Open-addressing table of 1021 slots keyed by 64-bit addresses, double hashing.
// ----------------------------------------------------------------------------
// One item at a time. After reset the slot memory is cleared one slot per
// cycle with the input stalled. An item then passes through FNV-1 hashing,
// modulo folding, a read state and a check state per probe over the slot
// memory, and a commit; key 0 makes no probes. The result stays on the out_
// ports until taken, and the next item is taken only after that. Key 0 is
// rejected with status full.
module double_hash_table_engine import dht_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [63:0] in_key,
  input  logic [31:0] in_block_size,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [31:0] out_size_out,
  output logic [9:0]  out_entry_count
);

  dht_cmd_t cmd;
  dht_sts_t sts;

  dht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_free (!out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  dht_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_func         (in_func),
    .in_key          (in_key),
    .in_block_size   (in_block_size),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_size_out    (out_size_out),
    .out_entry_count (out_entry_count)
  );

endmodule

FILE: test/tb_double_hash_table_engine.sv
// ----------------------------------------------------------------------------
// tb_double_hash_table_engine
// Self-checking bench for the double-hashing table engine. A directed table
// covers zero keys, extreme keys and sizes, every function code, misses and
// a shadowed duplicate behind a deleted slot. Random traffic over a small
// key pool follows, with a stall burst and a drain pause. The table is then
// filled to capacity to reach the full case. Results are compared with an
// in-bench table model, or with a checked row's values in the directed table.
// ----------------------------------------------------------------------------
module tb_double_hash_table_engine;
  import dht_pkg::*;

  typedef struct {
    status_t     st;
    logic [31:0] sz;
    logic [9:0]  cnt;
  } result_t;

  typedef struct {
    func_t       f;
    logic [63:0] k;
    logic [31:0] s;
    bit          chk;
    status_t     st;
    logic [31:0] so;
    logic [9:0]  cnt;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_func;
  logic [63:0] in_key;
  logic [31:0] in_block_size;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic [31:0] out_size_out;
  logic [9:0]  out_entry_count;

  double_hash_table_engine dut (.*);

  logic [63:0] slot_key [TableCapacity];
  logic [31:0] slot_size [TableCapacity];
  int unsigned live_count;
  result_t     pending_q [$];
  int          errors;
  bit          quiet;
  bit          hold_go;
  int          hold_cnt;
  logic [63:0] key_pool [48];

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] fnv1(input logic [63:0] k);
    logic [63:0] h;
    h = FnvBasis;
    for (int b = 0; b < 8; b++) begin
      h = h * FnvMult;
      h = h ^ ((k >> (8 * b)) & 64'hFF);
    end
    return h;
  endfunction

  function automatic int find_slot(input logic [63:0] k, input bit also_empty);
    logic [63:0] start, step, idx;
    start = fnv1(k) % TableCapacity;
    step = (HashPrime - (k % HashPrime)) % TableCapacity;
    idx = start;
    for (int i = 0; i < TableCapacity; i++) begin
      if (i > 0 && idx == start) break;
      if (slot_key[idx] == k || (also_empty && slot_key[idx] == 0)) return int'(idx);
      idx = (idx + step) % TableCapacity;
    end
    return -1;
  endfunction

  function automatic result_t table_apply(input logic [1:0] f, input logic [63:0] k,
                                          input logic [31:0] s);
    result_t r;
    int slot;
    r.sz = 0;
    if (k == 0) begin
      r.st = ST_FULL;
    end else if (f == FN_INSERT) begin
      slot = find_slot(k, 1);
      if (slot < 0) begin
        r.st = ST_FULL;
      end else begin
        if (slot_key[slot] == k) begin
          r.st = ST_UPDATED;
        end else begin
          r.st = ST_INSERTED;
          live_count = (live_count + 1) & 11'h7FF;
        end
        slot_key[slot] = k;
        slot_size[slot] = s;
        r.sz = s;
      end
    end else begin
      slot = find_slot(k, 0);
      if (slot < 0) begin
        r.st = ST_MISS;
      end else if (f == FN_DELETE) begin
        r.sz = slot_size[slot];
        slot_key[slot] = 0;
        slot_size[slot] = 0;
        live_count = (live_count - 1) & 11'h7FF;
        r.st = ST_DELETED;
      end else begin
        r.sz = slot_size[slot];
        r.st = ST_FOUND;
      end
    end
    r.cnt = live_count[9:0];
    return r;
  endfunction

  task automatic send(input logic [1:0] f, input logic [63:0] k, input logic [31:0] s,
                      input bit chk, input result_t typed);
    result_t r;
    while (!quiet && $urandom_range(99) < 17) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_func <= f;
    in_key <= k;
    in_block_size <= s;
    do @(posedge clk); while (in_stall);
    r = table_apply(f, k, s);
    pending_q.push_back(chk ? typed : r);
  endtask

  task automatic send_rand(input logic [1:0] f, input logic [63:0] k, input logic [31:0] s);
    result_t none;
    none = '{ST_FULL, 0, 0};
    send(f, k, s, 0, none);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  // result side: stalls, long hold-off, compare
  initial begin
    result_t e;
    out_stall <= 0;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_q.size() == 0) begin
          $display("%0t: unexpected item status %0d size %0d count %0d", $time,
                   out_status, out_size_out, out_entry_count);
          errors++;
        end else begin
          e = pending_q.pop_front();
          if (out_status !== e.st) begin
            $display("%0t: status exp %0d got %0d", $time, e.st, out_status);
            errors++;
          end
          if (out_size_out !== e.sz) begin
            $display("%0t: size exp %0d got %0d", $time, e.sz, out_size_out);
            errors++;
          end
          if (out_entry_count !== e.cnt) begin
            $display("%0t: count exp %0d got %0d", $time, e.cnt, out_entry_count);
            errors++;
          end
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1;
      end else if (hold_go) begin
        hold_go = 0;
        hold_cnt = 600;
        out_stall <= 1;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 17);
      end
    end
  end

  // watchdog on cycles without any handshake
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 20000) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    row_t        rows [$];
    logic [63:0] k1, k2, kf, fill_keys [$];
    logic [63:0] k;
    logic [1:0]  f;
    int          pick;
    result_t     typed;

    errors = 0;
    quiet = 0;
    hold_go = 0;
    live_count = 0;
    foreach (slot_key[i]) begin
      slot_key[i] = 0;
      slot_size[i] = 0;
    end
    rst_n <= 0;
    in_valid <= 0;
    in_func <= FN_INSERT;
    in_key <= 0;
    in_block_size <= 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;

    // two keys sharing a home slot
    k1 = 64'h0123_4567_89AB_CDEF;
    k2 = k1 + 1;
    while (fnv1(k2) % TableCapacity != fnv1(k1) % TableCapacity) k2++;

    rows.push_back('{FN_LOOKUP, 64'd1, 32'd5, 1, ST_MISS, 32'd0, 10'd0});
    rows.push_back('{FN_INSERT, 64'd0, 32'hFFFF_FFFF, 1, ST_FULL, 32'd0, 10'd0});
    rows.push_back('{FN_DELETE, 64'd0, 32'd0, 1, ST_FULL, 32'd0, 10'd0});
    rows.push_back('{FN_LOOKUP, 64'd0, 32'd0, 1, ST_FULL, 32'd0, 10'd0});
    rows.push_back('{FN_SPARE, 64'd0, 32'd0, 1, ST_FULL, 32'd0, 10'd0});
    rows.push_back('{FN_INSERT, '1, 32'hFFFF_FFFF, 1, ST_INSERTED, 32'hFFFF_FFFF, 10'd1});
    rows.push_back('{FN_LOOKUP, '1, 32'd0, 1, ST_FOUND, 32'hFFFF_FFFF, 10'd1});
    rows.push_back('{FN_INSERT, '1, 32'd0, 1, ST_UPDATED, 32'd0, 10'd1});
    rows.push_back('{FN_SPARE, '1, 32'd7, 1, ST_FOUND, 32'd0, 10'd1});
    rows.push_back('{FN_INSERT, 64'd1, 32'd1, 1, ST_INSERTED, 32'd1, 10'd2});
    rows.push_back('{FN_DELETE, '1, 32'd0, 1, ST_DELETED, 32'd0, 10'd1});
    rows.push_back('{FN_DELETE, '1, 32'd0, 1, ST_MISS, 32'd0, 10'd1});
    rows.push_back('{FN_INSERT, k1, 32'h1111, 0, ST_FULL, 0, 0});
    rows.push_back('{FN_INSERT, k2, 32'h2222, 0, ST_FULL, 0, 0});
    rows.push_back('{FN_DELETE, k1, 32'd0, 0, ST_FULL, 0, 0});
    rows.push_back('{FN_INSERT, k2, 32'h3333, 0, ST_FULL, 0, 0});
    rows.push_back('{FN_LOOKUP, k2, 32'd0, 0, ST_FULL, 0, 0});
    rows.push_back('{FN_DELETE, k2, 32'd0, 0, ST_FULL, 0, 0});
    rows.push_back('{FN_LOOKUP, k2, 32'd0, 0, ST_FULL, 0, 0});
    rows.push_back('{FN_DELETE, k2, 32'd0, 0, ST_FULL, 0, 0});
    rows.push_back('{FN_DELETE, 64'd1, 32'd0, 1, ST_DELETED, 32'd1, 10'd0});
    foreach (rows[i]) begin
      typed = '{rows[i].st, rows[i].so, rows[i].cnt};
      send(rows[i].f, rows[i].k, rows[i].s, rows[i].chk, typed);
    end

    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    for (int n = 0; n < 80; n++) begin
      if (n == 15) hold_go = 1;
      if (n == 40) drain();
      quiet = (n >= 45 && n < 75);
      pick = $urandom_range(99);
      if (pick < 4) k = 0;
      else if (pick < 14) k = {$urandom, $urandom};
      else k = key_pool[$urandom_range(47)];
      pick = $urandom_range(99);
      f = pick < 45 ? FN_INSERT : pick < 65 ? FN_DELETE : pick < 95 ? FN_LOOKUP : FN_SPARE;
      send_rand(f, k, $urandom);
    end
    quiet = 0;

    // fill to capacity
    while (live_count < TableCapacity) begin
      kf = {$urandom, $urandom} | 64'd1;
      fill_keys.push_back(kf);
      send_rand(FN_INSERT, kf, $urandom);
    end
    send_rand(FN_INSERT, {$urandom, $urandom} | 64'd1, $urandom);
    send_rand(FN_INSERT, fill_keys[0], 32'hFFFF_FFFF);
    send_rand(FN_LOOKUP, {$urandom, $urandom} | 64'd1, 32'd0);
    for (int n = 0; n < 20; n++) begin
      send_rand(FN_DELETE, fill_keys[$urandom_range(fill_keys.size() - 1)], 32'd0);
      send_rand(FN_LOOKUP, fill_keys[$urandom_range(fill_keys.size() - 1)], 32'd0);
    end

    @(posedge clk);
    in_valid <= 0;
    drain();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
